// ===== sv/disk_head_request_scheduler_defines.svh =====
// Assertion macros shared by the disk head request scheduler RTL.
// No dependencies; included by files that carry concurrent assertions.
`ifndef DISK_HEAD_REQUEST_SCHEDULER_DEFINES_SVH
`define DISK_HEAD_REQUEST_SCHEDULER_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define DHRS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Condition implies consequence in the next cycle.
`define DHRS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/dhrs_pkg.sv =====
// Shared widths, register codes and cell interface types for the scheduler.
// No dependencies; used by dhrs_cell and disk_head_request_scheduler.
`timescale 1ns / 1ps

package dhrs_pkg;

    localparam int TRACK_W = 16;
    localparam int DIST_W  = 17;
    localparam int TOTAL_W = 24;
    localparam int RIDX_W  = 5;
    localparam int CFG_W   = 2;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam logic [CFG_W-1:0] CFG_SCAN_MODE   = 2'd0;
    localparam logic [CFG_W-1:0] CFG_TRACK_COUNT = 2'd1;
    localparam logic [CFG_W-1:0] CFG_START_TRACK = 2'd2;

    // Search token walking down the cell row (index travels beside it).
    typedef struct packed {
        logic               live;
        logic               found;
        logic [TRACK_W-1:0] seek;
        logic [TRACK_W-1:0] track;
    } t_token;

    // Broadcast control from the sequencer to every cell.
    typedef struct packed {
        logic               load;
        logic               clamp;
        logic               mark;
        logic               scan;
        logic               sweep_down;
        logic [TRACK_W-1:0] head;
        logic [TRACK_W-1:0] last;
        logic [TRACK_W-1:0] wr_track;
    } t_cell_ctl;

endpackage

// ===== sv/dhrs_cell.sv =====
// One request slot of the scheduler row: stored track, pending flag and one
// compare stage of the nearest-request search. Depends on dhrs_pkg.
`timescale 1ns / 1ps

module dhrs_cell #(
    parameter int IDX_W    = 5,
    parameter int CELL_IDX = 0
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  dhrs_pkg::t_cell_ctl i_ctl,
    input  logic [IDX_W-1:0]   i_sel_idx,
    input  dhrs_pkg::t_token   i_tok,
    input  logic [IDX_W-1:0]   i_tok_idx,
    output dhrs_pkg::t_token   o_tok,
    output logic [IDX_W-1:0]   o_tok_idx
);

    logic [dhrs_pkg::TRACK_W-1:0] r_track;
    logic                         r_valid;
    dhrs_pkg::t_token             r_tok;
    dhrs_pkg::t_token             n_tok;
    logic [IDX_W-1:0]             r_tok_idx;
    logic [IDX_W-1:0]             n_tok_idx;

    logic                         w_hit;
    logic                         w_ge;
    logic                         w_ahead;
    logic                         w_take;
    logic [dhrs_pkg::TRACK_W-1:0] w_dist;

    assign w_hit = (i_sel_idx == IDX_W'(CELL_IDX));

    always_comb begin
        w_ge    = (r_track >= i_ctl.head);
        w_dist  = w_ge ? (r_track - i_ctl.head) : (i_ctl.head - r_track);
        // sweep only looks at or ahead of the head
        w_ahead = !i_ctl.scan || (i_ctl.sweep_down ? (r_track <= i_ctl.head) : w_ge);
        // strict compare: earlier cell keeps a tie
        w_take  = r_valid && w_ahead && (!i_tok.found || (w_dist < i_tok.seek));

        n_tok       = i_tok;
        n_tok_idx   = i_tok_idx;
        n_tok.found = i_tok.found || w_take;
        if (w_take) begin
            n_tok.seek  = w_dist;
            n_tok.track = r_track;
            n_tok_idx   = IDX_W'(CELL_IDX);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.load && w_hit) begin
            r_valid <= 1'b1;
        end else if (i_ctl.mark && w_hit) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load && w_hit) begin
            r_track <= i_ctl.wr_track;
        end else if (i_ctl.clamp && (r_track > i_ctl.last)) begin
            r_track <= i_ctl.last;
        end
    end

    // only the live bit needs a reset; the payload follows it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.live <= 1'b0;
        end else begin
            r_tok.live <= n_tok.live;
        end
        r_tok.found <= n_tok.found;
        r_tok.seek  <= n_tok.seek;
        r_tok.track <= n_tok.track;
        r_tok_idx   <= n_tok_idx;
    end

    assign o_tok     = r_tok;
    assign o_tok_idx = r_tok_idx;

endmodule

// ===== sv/disk_head_request_scheduler.sv =====
// Disk head request scheduler: shortest-seek-first and sweep ordering of a
// batch of track requests. Depends on dhrs_pkg, dhrs_cell and the defines header.
`timescale 1ns / 1ps
//
// Usage
//  Input: a request transfers on a rising edge with i_start high and o_busy
//  low. Requests fill the cell row in arrival order; past MAX_REQUESTS they
//  are dropped. The request with i_batch_end high (stored if room) starts
//  scheduling and o_busy stays high until the last result is out.
//  Config: i_cfg_valid/o_cfg_ready write channel, o_cfg_ready is always high.
//  Index 0 scan_mode, 1 track_count, 2 start_track; other indexes are ignored.
//  Write only while o_busy is low.
//  Output: each result is held for exactly one cycle, marked by o_strobe;
//  the receiver cannot stall. o_final_res flags the last one of the batch.
//  Flow: loading accepts one request per cycle while o_busy is low. After the
//  batch end, a clamp state runs, then each result costs one search token pass
//  down the row of MAX_REQUESTS cells; a sweep reversal adds one more pass.
//  Results thus come out one at a time, set by the single token walking the
//  cell chain.
//  Reset (synchronous, active low) empties the row, clears the sequencer and
//  restores scan_mode 0, track_count 200, start_track 0.
//
module disk_head_request_scheduler #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic [dhrs_pkg::TRACK_W-1:0]  i_track,
    input  logic                          i_batch_end,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [dhrs_pkg::CFG_W-1:0]    i_cfg_index,
    input  logic [dhrs_pkg::TRACK_W-1:0]  i_cfg_data,
    output logic                          o_strobe,
    output logic [dhrs_pkg::TRACK_W-1:0]  o_served_track,
    output logic [dhrs_pkg::RIDX_W-1:0]   o_request_index,
    output logic [dhrs_pkg::DIST_W-1:0]   o_seek_distance,
    output logic [dhrs_pkg::TOTAL_W-1:0]  o_total_movement,
    output logic                          o_final_res
);

`include "disk_head_request_scheduler_defines.svh"

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int TW    = dhrs_pkg::TRACK_W;
    localparam int DW    = dhrs_pkg::DIST_W;
    localparam int SW    = dhrs_pkg::TOTAL_W;
    localparam int RW    = dhrs_pkg::RIDX_W;

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_PREP   = 3'b010,
        S_SEARCH = 3'b100
    } t_state;

    // config
    logic          r_scan;
    logic [TW-1:0] r_track_count;
    logic [TW-1:0] r_start;

    // sequencer
    t_state         r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [CNT_W-1:0] r_done_cnt, n_done_cnt;
    logic [TW-1:0]  r_head, n_head;
    logic           r_sweep_down, n_sweep_down;
    logic [SW-1:0]  r_total, n_total;
    logic [DW-1:0]  r_travel, n_travel;
    logic           r_launch, n_launch;

    // result register
    logic           r_o_valid, n_o_valid;
    logic [TW-1:0]  r_o_track, n_o_track;
    logic [RW-1:0]  r_o_idx, n_o_idx;
    logic [DW-1:0]  r_o_dist, n_o_dist;
    logic [SW-1:0]  r_o_total, n_o_total;
    logic           r_o_final, n_o_final;

    dhrs_pkg::t_cell_ctl w_ctl;
    logic [IDX_W-1:0]    w_sel_idx;
    dhrs_pkg::t_token    w_tok [MAX_REQUESTS+1];
    logic [IDX_W-1:0]    w_tidx [MAX_REQUESTS+1];
    logic [MAX_REQUESTS-1:0] w_live;
    dhrs_pkg::t_token    w_end;
    logic [IDX_W-1:0]    w_end_idx;

    logic [TW-1:0]    w_last;
    logic [TW-1:0]    w_in_trk;
    logic             w_accept;
    logic [DW-1:0]    w_dist;
    logic [SW:0]      w_sum;
    logic [CNT_W-1:0] w_done_inc;
    logic             w_final;
    logic [IDX_W+RW-1:0] w_idx_ext;

    assign w_last   = (r_track_count == '0) ? '0 : (r_track_count - TW'(1));
    assign w_in_trk = (i_track > w_last) ? w_last : i_track;
    assign w_accept = i_start && (r_state == S_IDLE);

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;

    // ---------------- configuration registers ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan        <= 1'b0;
            r_track_count <= TW'(200);
            r_start       <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                dhrs_pkg::CFG_SCAN_MODE:   r_scan        <= i_cfg_data[0];
                dhrs_pkg::CFG_TRACK_COUNT: r_track_count <= i_cfg_data;
                dhrs_pkg::CFG_START_TRACK: r_start       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- cell row ----------------
    assign w_tok[0]  = '{live: r_launch, found: 1'b0, seek: '0, track: '0};
    assign w_tidx[0] = '0;

    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        dhrs_cell #(
            .IDX_W    (IDX_W),
            .CELL_IDX (g)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_sel_idx (w_sel_idx),
            .i_tok     (w_tok[g]),
            .i_tok_idx (w_tidx[g]),
            .o_tok     (w_tok[g+1]),
            .o_tok_idx (w_tidx[g+1])
        );
        assign w_live[g] = w_tok[g+1].live;
    end

    assign w_end     = w_tok[MAX_REQUESTS];
    assign w_end_idx = w_tidx[MAX_REQUESTS];

    // result arithmetic: pending reversal travel plus the found seek
    assign w_dist     = r_travel + DW'(w_end.seek);
    assign w_sum      = {1'b0, r_total} + (SW+1)'(w_dist);
    assign w_done_inc = r_done_cnt + CNT_W'(1);
    assign w_final    = (w_done_inc == r_count);
    assign w_idx_ext  = (IDX_W+RW)'(w_end_idx);

    // ---------------- sequencer ----------------
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_done_cnt   = r_done_cnt;
        n_head       = r_head;
        n_sweep_down = r_sweep_down;
        n_total      = r_total;
        n_travel     = r_travel;
        n_launch     = 1'b0;
        n_o_valid    = 1'b0;
        n_o_track    = r_o_track;
        n_o_idx      = r_o_idx;
        n_o_dist     = r_o_dist;
        n_o_total    = r_o_total;
        n_o_final    = r_o_final;

        w_ctl            = '0;
        w_ctl.scan       = r_scan;
        w_ctl.sweep_down = r_sweep_down;
        w_ctl.head       = r_head;
        w_ctl.last       = w_last;
        w_ctl.wr_track   = w_in_trk;
        w_sel_idx        = r_count[IDX_W-1:0];

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (r_count < CNT_W'(MAX_REQUESTS)) begin
                        w_ctl.load = 1'b1;
                        n_count    = r_count + CNT_W'(1);
                    end
                    if (i_batch_end) begin
                        n_state = S_PREP;
                    end
                end
            end
            S_PREP: begin
                // re-clamp stored tracks against the current track count
                w_ctl.clamp  = 1'b1;
                n_head       = (r_start < r_track_count) ? r_start : '0;
                n_sweep_down = 1'b1;
                n_total      = '0;
                n_travel     = '0;
                n_done_cnt   = '0;
                n_launch     = 1'b1;
                n_state      = S_SEARCH;
            end
            S_SEARCH: begin
                if (w_end.live) begin
                    if (w_end.found) begin
                        w_ctl.mark = 1'b1;
                        w_sel_idx  = w_end_idx;
                        n_head     = w_end.track;
                        n_travel   = '0;
                        n_total    = w_sum[SW] ? dhrs_pkg::TOTAL_MAX : w_sum[SW-1:0];
                        n_o_valid  = 1'b1;
                        n_o_track  = w_end.track;
                        n_o_idx    = w_idx_ext[RW-1:0];
                        n_o_dist   = w_dist;
                        n_o_total  = n_total;
                        n_o_final  = w_final;
                        if (w_final) begin
                            n_state      = S_IDLE;
                            n_count      = '0;
                            n_sweep_down = 1'b1;
                        end else begin
                            n_done_cnt = w_done_inc;
                            n_launch   = 1'b1;
                        end
                    end else if (r_scan) begin
                        // nothing ahead: run to the end track and turn
                        n_travel     = r_sweep_down ? DW'(r_head) : DW'(w_last - r_head);
                        n_head       = r_sweep_down ? '0 : w_last;
                        n_sweep_down = !r_sweep_down;
                        n_launch     = 1'b1;
                    end else begin
                        n_state = S_IDLE;
                        n_count = '0;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_done_cnt   <= '0;
            r_head       <= '0;
            r_sweep_down <= 1'b1;
            r_total      <= '0;
            r_travel     <= '0;
            r_launch     <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_done_cnt   <= n_done_cnt;
            r_head       <= n_head;
            r_sweep_down <= n_sweep_down;
            r_total      <= n_total;
            r_travel     <= n_travel;
            r_launch     <= n_launch;
            r_o_valid    <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o_track <= n_o_track;
        r_o_idx   <= n_o_idx;
        r_o_dist  <= n_o_dist;
        r_o_total <= n_o_total;
        r_o_final <= n_o_final;
    end

    assign o_strobe         = r_o_valid;
    assign o_served_track   = r_o_track;
    assign o_request_index  = r_o_idx;
    assign o_seek_distance  = r_o_dist;
    assign o_total_movement = r_o_total;
    assign o_final_res      = r_o_final;

    // ---------------- assertions ----------------
    `DHRS_ASSERT_SAME(a_one_token, i_clk, i_rst_n, 1'b1, $onehot0(w_live),
        "more than one search token in the cell row")
    `DHRS_ASSERT_SAME(a_done_below_count, i_clk, i_rst_n, r_state == S_SEARCH,
        r_done_cnt < r_count, "served count reached request count while searching")
    `DHRS_ASSERT_SAME(a_miss_only_in_scan, i_clk, i_rst_n, w_end.live && !w_end.found,
        r_scan, "shortest seek search found no pending request")
    `DHRS_ASSERT_NEXT(a_found_emits, i_clk, i_rst_n,
        r_state == S_SEARCH && w_end.live && w_end.found, o_strobe,
        "found request did not produce a result")
    `DHRS_ASSERT_SAME(a_final_idle, i_clk, i_rst_n, o_strobe && o_final_res,
        r_state == S_IDLE && r_count == '0, "final result while batch still open")

endmodule

// ===== tb/dhrs_order_checker.sv =====
// Scoreboard for the disk head request scheduler: tracks register writes and
// request transfers, predicts each batch's service order, checks every result.
// Depends on dhrs_pkg.
`timescale 1ns / 1ps

module dhrs_order_checker #(
    parameter int MAX_REQUESTS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic                         i_busy,
    input  logic [dhrs_pkg::TRACK_W-1:0] i_track,
    input  logic                         i_batch_end,
    input  logic                         i_cfg_valid,
    input  logic                         i_cfg_ready,
    input  logic [dhrs_pkg::CFG_W-1:0]   i_cfg_index,
    input  logic [dhrs_pkg::TRACK_W-1:0] i_cfg_data,
    input  logic                         i_strobe,
    input  logic [dhrs_pkg::TRACK_W-1:0] i_served_track,
    input  logic [dhrs_pkg::RIDX_W-1:0]  i_request_index,
    input  logic [dhrs_pkg::DIST_W-1:0]  i_seek_distance,
    input  logic [dhrs_pkg::TOTAL_W-1:0] i_total_movement,
    input  logic                         i_final_res,
    output int                           o_mismatches,
    output int                           o_pending
);

    typedef struct packed {
        logic [dhrs_pkg::TRACK_W-1:0] track;
        logic [dhrs_pkg::RIDX_W-1:0]  index;
        logic [dhrs_pkg::DIST_W-1:0]  step;
        logic [dhrs_pkg::TOTAL_W-1:0] total;
        logic                         last;
    } t_service;

    t_service service_q[$];

    // register copies
    logic                         sweep_scan;
    logic [dhrs_pkg::TRACK_W-1:0] tracks_cfg;
    logic [dhrs_pkg::TRACK_W-1:0] start_cfg;

    // batch store and head state
    logic [dhrs_pkg::TRACK_W-1:0] queued_track [MAX_REQUESTS];
    logic                         served       [MAX_REQUESTS];
    int                           queued_cnt;
    logic [dhrs_pkg::TRACK_W-1:0] head;
    logic                         heading_down;

    function automatic logic [dhrs_pkg::TRACK_W-1:0] top_track();
        return (tracks_cfg == '0) ? '0 : tracks_cfg - 1'b1;
    endfunction

    function automatic logic [dhrs_pkg::TRACK_W-1:0] clamp_trk(
        input logic [dhrs_pkg::TRACK_W-1:0] t);
        return (t > top_track()) ? top_track() : t;
    endfunction

    function automatic logic [dhrs_pkg::TRACK_W-1:0] gap(
        input logic [dhrs_pkg::TRACK_W-1:0] a,
        input logic [dhrs_pkg::TRACK_W-1:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    // Closest unserved request, earliest load wins ties; with ahead_only set,
    // requests behind the head in the sweep direction are skipped.
    function automatic int nearest(input logic ahead_only);
        int                           best;
        logic [dhrs_pkg::TRACK_W-1:0] best_d;
        logic [dhrs_pkg::TRACK_W-1:0] t;
        best   = -1;
        best_d = '0;
        for (int i = 0; i < queued_cnt; i++) begin
            t = clamp_trk(queued_track[i]);
            if (served[i])
                continue;
            if (ahead_only && (heading_down ? (t > head) : (t < head)))
                continue;
            if (best < 0 || gap(t, head) < best_d) begin
                best   = i;
                best_d = gap(t, head);
            end
        end
        return best;
    endfunction

    task automatic plan_service_order();
        int                           pick;
        logic [dhrs_pkg::TRACK_W-1:0] t;
        logic [dhrs_pkg::TRACK_W-1:0] end_trk;
        logic [dhrs_pkg::DIST_W-1:0]  step;
        logic [dhrs_pkg::TOTAL_W:0]   sum;
        logic [dhrs_pkg::TOTAL_W-1:0] total;
        t_service                     s;
        head         = (start_cfg < tracks_cfg) ? start_cfg : '0;
        heading_down = 1'b1;
        total        = '0;
        for (int i = 0; i < MAX_REQUESTS; i++)
            served[i] = 1'b0;
        for (int k = 0; k < queued_cnt; k++) begin
            step = '0;
            pick = nearest(sweep_scan);
            if (sweep_scan && pick < 0) begin
                // nothing ahead: run to the end track, turn around
                end_trk      = heading_down ? '0 : top_track();
                step         = gap(head, end_trk);
                head         = end_trk;
                heading_down = !heading_down;
                pick         = nearest(1'b1);
            end
            if (pick < 0)
                break;
            t            = clamp_trk(queued_track[pick]);
            step         = step + gap(t, head);
            served[pick] = 1'b1;
            head         = t;
            sum          = total + step;
            total        = (sum > dhrs_pkg::TOTAL_MAX) ? dhrs_pkg::TOTAL_MAX
                                                       : sum[dhrs_pkg::TOTAL_W-1:0];
            s.track      = t;
            s.index      = pick[dhrs_pkg::RIDX_W-1:0];
            s.step       = step;
            s.total      = total;
            s.last       = (k + 1 == queued_cnt);
            service_q    = {service_q, s};
        end
        queued_cnt = 0;
    endtask

    task automatic compare_field(input string name, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got) begin
            o_mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        t_service s;
        if (!i_rst_n) begin
            sweep_scan   = 1'b0;
            tracks_cfg   = 16'd200;
            start_cfg    = '0;
            queued_cnt   = 0;
            service_q.delete();
            o_mismatches = 0;
            o_pending    = 0;
        end else begin
            if (i_strobe === 1'b1) begin
                if (service_q.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: result expected none actual track %0d index %0d",
                             $time, i_served_track, i_request_index);
                end else begin
                    s = service_q.pop_front();
                    compare_field("served_track", s.track, i_served_track);
                    compare_field("request_index", s.index, i_request_index);
                    compare_field("seek_distance", s.step, i_seek_distance);
                    compare_field("total_movement", s.total, i_total_movement);
                    compare_field("final_res", s.last, i_final_res);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    dhrs_pkg::CFG_SCAN_MODE:   sweep_scan = i_cfg_data[0];
                    dhrs_pkg::CFG_TRACK_COUNT: tracks_cfg = i_cfg_data;
                    dhrs_pkg::CFG_START_TRACK: start_cfg  = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_start && !i_busy) begin
                if (queued_cnt < MAX_REQUESTS) begin
                    queued_track[queued_cnt] = clamp_trk(i_track);
                    queued_cnt++;
                end
                if (i_batch_end)
                    plan_service_order();
            end
            o_pending = service_q.size();
        end
    end

endmodule

// ===== tb/tb.sv =====
// Top of the scheduler testbench: clock, reset, request and register stimulus,
// verdict. Depends on dhrs_pkg, disk_head_request_scheduler, dhrs_order_checker.
`timescale 1ns / 1ps

module tb;

    localparam int              TW         = dhrs_pkg::TRACK_W;
    localparam int              MAX_REQ    = 32;
    localparam int              ITEM_GOAL  = 350;
    // up to two search passes per result; generous margin
    localparam int              CYCLE_CAP  = 400000;
    // quiet time after the last result, covers one full search pass
    localparam int              SETTLE     = MAX_REQ + 8;
    localparam logic [dhrs_pkg::CFG_W-1:0] CFG_UNUSED = 2'd3;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_start;
    logic                         o_busy;
    logic [TW-1:0]                i_track;
    logic                         i_batch_end;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic [dhrs_pkg::CFG_W-1:0]   i_cfg_index;
    logic [TW-1:0]                i_cfg_data;
    logic                         o_strobe;
    logic [TW-1:0]                o_served_track;
    logic [dhrs_pkg::RIDX_W-1:0]  o_request_index;
    logic [dhrs_pkg::DIST_W-1:0]  o_seek_distance;
    logic [dhrs_pkg::TOTAL_W-1:0] o_total_movement;
    logic                         o_final_res;

    int mismatches;
    int pending;
    int cycles;

    // stimulus bookkeeping
    int            stored_items;  // requests that land in the store
    int            batch_fill;
    int            burst_left;
    bit            gaps_on;
    int            tc;
    int            st;
    int            last_trk;
    int            batch_len;
    int            batches;
    logic [TW-1:0] prev_trk;

    disk_head_request_scheduler #(
        .MAX_REQUESTS(MAX_REQ)
    ) i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_track         (i_track),
        .i_batch_end     (i_batch_end),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_strobe        (o_strobe),
        .o_served_track  (o_served_track),
        .o_request_index (o_request_index),
        .o_seek_distance (o_seek_distance),
        .o_total_movement(o_total_movement),
        .o_final_res     (o_final_res)
    );

    dhrs_order_checker #(
        .MAX_REQUESTS(MAX_REQ)
    ) i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .i_busy          (o_busy),
        .i_track         (i_track),
        .i_batch_end     (i_batch_end),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_strobe        (o_strobe),
        .i_served_track  (o_served_track),
        .i_request_index (o_request_index),
        .i_seek_distance (o_seek_distance),
        .i_total_movement(o_total_movement),
        .i_final_res     (o_final_res),
        .o_mismatches    (mismatches),
        .o_pending       (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a missing result ends here.
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_CAP) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic pause(input int n);
        i_start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    // Request transfer. i_start stays high so back-to-back requests go out on
    // consecutive edges; the sender then drops into a random gap at the end
    // of each burst when gaps are enabled.
    task automatic send(input logic [TW-1:0] trk, input logic last_one);
        i_start     <= 1'b1;
        i_track     <= trk;
        i_batch_end <= last_one;
        do @(posedge i_clk); while (o_busy);
        if (batch_fill < MAX_REQ)
            stored_items++;
        batch_fill = last_one ? 0 : batch_fill + 1;
        prev_trk   = trk;
        if (gaps_on) begin
            if (burst_left == 0) begin
                pause($urandom_range(1, 8));
                burst_left = $urandom_range(1, 12);
            end else begin
                burst_left--;
            end
        end
    endtask

    // Hold off until every predicted result has come out and the block is
    // idle, then give it a full search pass of quiet time.
    task automatic drain();
        i_start <= 1'b0;
        @(posedge i_clk);
        while (pending != 0 || o_busy) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    // One register transfer; valid drops for a cycle after each write.
    task automatic write_reg(input logic [dhrs_pkg::CFG_W-1:0] idx,
                             input logic [TW-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Track mix: ends of the disk, past the end, full 16-bit range, repeats
    // of the previous request (ties), and plenty of in-range values.
    function automatic logic [TW-1:0] random_track(input int last);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return TW'(last);
            2:       return TW'($urandom_range(last + 1, 65535));
            3:       return TW'($urandom_range(0, 65535));
            4:       return prev_trk;
            default: return TW'($urandom_range(0, last));
        endcase
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_track      = '0;
        i_batch_end  = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        cycles       = 0;
        stored_items = 0;
        batch_fill   = 0;
        burst_left   = 0;
        gaps_on      = 1'b0;
        prev_trk     = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        // Reset config (SSTF, 200 tracks, start 0): clamp past the end,
        // tie between two requests at 50 goes to the earlier one.
        send(16'd100, 1'b0);
        send(16'hFFFF, 1'b0);
        send(16'd50, 1'b0);
        send(16'd50, 1'b0);
        send(16'd150, 1'b1);
        drain();

        // Sweep from track 0: no step below 0, duplicate track served together.
        write_reg(dhrs_pkg::CFG_SCAN_MODE, 16'd1);
        send(16'd0, 1'b0);
        send(16'd10, 1'b0);
        send(16'd199, 1'b0);
        send(16'd10, 1'b1);
        drain();

        // Sweep from 120: down to the request at 0, turn there, then up.
        write_reg(dhrs_pkg::CFG_START_TRACK, 16'd120);
        send(16'd130, 1'b0);
        send(16'd20, 1'b0);
        send(16'd199, 1'b0);
        send(16'd0, 1'b0);
        send(16'd125, 1'b1);
        drain();

        // Start beyond the disk falls back to 0; track count shrinks in the
        // middle of a batch so stored requests get clamped again.
        write_reg(dhrs_pkg::CFG_SCAN_MODE, 16'd0);
        write_reg(dhrs_pkg::CFG_TRACK_COUNT, 16'd50);
        write_reg(dhrs_pkg::CFG_START_TRACK, 16'd60);
        send(16'd40, 1'b0);
        send(16'd45, 1'b0);
        pause(1);
        write_reg(dhrs_pkg::CFG_TRACK_COUNT, 16'd30);
        send(16'd10, 1'b1);
        drain();

        // One-track and zero-track disks: everything lands on track 0.
        write_reg(dhrs_pkg::CFG_SCAN_MODE, 16'd1);
        write_reg(dhrs_pkg::CFG_TRACK_COUNT, 16'd1);
        send(16'hFFFF, 1'b0);
        send(16'd5, 1'b1);
        drain();
        write_reg(dhrs_pkg::CFG_TRACK_COUNT, 16'd0);
        send(16'd7, 1'b0);
        send(16'd0, 1'b1);
        drain();

        // Largest disk: longest possible seek (down to 0 and all the way up).
        write_reg(dhrs_pkg::CFG_TRACK_COUNT, 16'hFFFF);
        write_reg(dhrs_pkg::CFG_START_TRACK, 16'd65533);
        send(16'hFFFF, 1'b1);
        drain();
        write_reg(dhrs_pkg::CFG_START_TRACK, 16'hFFFE);
        send(16'd0, 1'b0);
        send(16'hFFFE, 1'b0);
        send(16'h8000, 1'b1);
        drain();

        // Write to the spare index must leave every register alone.
        write_reg(CFG_UNUSED, 16'hFFFF);
        send(16'h5555, 1'b0);
        send(16'hAAAA, 1'b1);

        // --- random phases ---
        // Each phase: wait for idle, new register set, a few batches. Most
        // batches are short; some overfill the store to hit the drop path.
        while (stored_items < ITEM_GOAL) begin
            drain();
            tc = 0;
            case ($urandom_range(0, 5))
                0: tc = 2;
                1: tc = $urandom_range(3, 16);
                2: tc = 200;
                3: tc = $urandom_range(2, 65535);
                4: tc = 65535;
                5: tc = $urandom_range(17, 1000);
            endcase
            last_trk = tc - 1;
            st = 0;
            case ($urandom_range(0, 4))
                0: st = 0;
                1: st = last_trk;
                2: st = $urandom_range(0, last_trk);
                3: st = $urandom_range(0, 65535);
                4: st = 65534;
            endcase
            write_reg(dhrs_pkg::CFG_SCAN_MODE, TW'($urandom_range(0, 1)));
            write_reg(dhrs_pkg::CFG_TRACK_COUNT, TW'(tc));
            write_reg(dhrs_pkg::CFG_START_TRACK, TW'(st));
            if ($urandom_range(0, 7) == 0)
                write_reg(CFG_UNUSED, TW'($urandom_range(0, 65535)));

            // about one phase in four runs with no sender gaps at all
            gaps_on    = ($urandom_range(0, 3) != 0);
            burst_left = $urandom_range(1, 12);
            batches    = $urandom_range(2, 5);
            repeat (batches) begin
                case ($urandom_range(0, 9))
                    0:       batch_len = $urandom_range(MAX_REQ + 1, MAX_REQ + 8);
                    1, 2:    batch_len = $urandom_range(9, 24);
                    default: batch_len = $urandom_range(1, 8);
                endcase
                for (int j = 0; j < batch_len; j++)
                    send(random_track(last_trk), j == batch_len - 1);
                // now and then the sender waits for the whole order to come out
                if ($urandom_range(0, 5) == 0)
                    drain();
            end
        end

        drain();
        if (mismatches == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
